### design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants of the RC4 stream cipher
// Item formats, key configuration bundle, sequencer states, register map.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int MaxKeyBytes = 32;
  localparam int KeyIdxW     = $clog2(MaxKeyBytes);
  localparam int KeyBits     = 8 * MaxKeyBytes;
  localparam int KeyLenW     = 6;
  localparam int SboxDepth   = 256;
  localparam int SboxAddrW   = $clog2(SboxDepth);
  localparam int ApbDataW    = 64;
  localparam int ApbAddrW    = 6;
  localparam int RegIdxW     = 3;

  // register indexes (byte address = 8 * index)
  localparam logic [RegIdxW-1:0] RegKeyLen     = 3'd0;
  localparam logic [RegIdxW-1:0] RegKeyLow     = 3'd1;
  localparam logic [RegIdxW-1:0] RegKeyMidLow  = 3'd2;
  localparam logic [RegIdxW-1:0] RegKeyMidHigh = 3'd3;
  localparam logic [RegIdxW-1:0] RegKeyHigh    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [KeyLenW-1:0] key_length;
    logic [KeyBits-1:0] key;
  } key_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RD_J,
    ST_K_WR_I,
    ST_K_WR_J,
    ST_P_RD_I,
    ST_P_RD_J,
    ST_P_WR_I,
    ST_P_WR_J,
    ST_P_OUT
  } state_e;

endpackage

### design/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher: RC4 byte cipher, top level
// Input and output item channels with valid/stall, APB key registers.
// ----------------------------------------------------------------------------
// Usage:
//   Program the key length (register 0) and key words (registers 1..4, at
//   byte addresses 8..32) while the block is idle. Each input item carries a
//   byte, a restart flag and a last flag; each gives exactly one output item
//   with the byte XOR keystream and the copied last flag.
//   An item that sets restart, or the first item after reset, first runs the
//   key schedule: an identity fill, then for each entry a read of S[j] and
//   writes of S[i] and S[j]. A keystream step reads S[i], reads S[j], writes
//   both back swapped and reads the keystream byte for the output register; a
//   new item is taken only after the last one is loaded. This order follows
//   from the one RAM: one read, one write per cycle, with registered read.
//   One result register sits at the output; while the receiver stalls, the
//   result holds there and the block finishes the next item up to the point
//   of loading it. Reset clears the key registers to length 16 and zero key,
//   and marks the block unkeyed; the permutation RAM is not cleared.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rc4_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rc4_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rc4_pkg::ApbAddrW-1:0] paddr,
  input  logic [rc4_pkg::ApbDataW-1:0] pwdata,
  output logic [rc4_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  rc4_pkg::key_cfg_t  cfg;
  rc4_pkg::out_item_t res_item;
  rc4_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               in_ready;
  logic               res_free;
  logic               res_load;

  rc4_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rc4_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_data_i),
    .in_ready_o (in_ready),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_item_o (res_item)
  );

  assign in_stall_o = !in_ready;
  assign res_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_d       = res_item;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted item keeps the input closed while it is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input reopened right after an accept");

  // a new result never overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_load && out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // a loaded result shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

### design/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram: generic single-write, single-read RAM
// Registered read; a read and a write to the same address return old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rc4_cfg.sv
// ----------------------------------------------------------------------------
// rc4_cfg: APB register file
// Holds key length and the four 64-bit key words; pready is tied high.
// ----------------------------------------------------------------------------
module rc4_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rc4_pkg::ApbAddrW-1:0]     paddr,
  input  logic [rc4_pkg::ApbDataW-1:0]     pwdata,
  output logic [rc4_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready,
  output rc4_pkg::key_cfg_t                cfg_o
);

  logic [rc4_pkg::KeyLenW-1:0]  key_len_q, key_len_d;
  logic [rc4_pkg::ApbDataW-1:0] key_w_q [4];
  logic [rc4_pkg::ApbDataW-1:0] key_w_d [4];
  logic [rc4_pkg::RegIdxW-1:0]  reg_idx;
  logic                         wr_en;

  assign reg_idx = paddr[rc4_pkg::ApbAddrW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    key_len_d = key_len_q;
    key_w_d   = key_w_q;
    if (wr_en) begin
      unique case (reg_idx)
        rc4_pkg::RegKeyLen:     key_len_d  = pwdata[rc4_pkg::KeyLenW-1:0];
        rc4_pkg::RegKeyLow:     key_w_d[0] = pwdata;
        rc4_pkg::RegKeyMidLow:  key_w_d[1] = pwdata;
        rc4_pkg::RegKeyMidHigh: key_w_d[2] = pwdata;
        rc4_pkg::RegKeyHigh:    key_w_d[3] = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rc4_pkg::RegKeyLen: begin
        prdata = {{(rc4_pkg::ApbDataW-rc4_pkg::KeyLenW){1'b0}}, key_len_q};
      end
      rc4_pkg::RegKeyLow:     prdata = key_w_q[0];
      rc4_pkg::RegKeyMidLow:  prdata = key_w_q[1];
      rc4_pkg::RegKeyMidHigh: prdata = key_w_q[2];
      rc4_pkg::RegKeyHigh:    prdata = key_w_q[3];
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= rc4_pkg::KeyLenW'(16);
      key_w_q   <= '{default: '0};
    end else begin
      key_len_q <= key_len_d;
      key_w_q   <= key_w_d;
    end
  end

  assign cfg_o.key_length = key_len_q;
  assign cfg_o.key        = {key_w_q[3], key_w_q[2], key_w_q[1], key_w_q[0]};

endmodule

### design/rc4_core.sv
// ----------------------------------------------------------------------------
// rc4_core: key schedule and keystream sequencer
// Drives one permutation RAM (one read, one write per cycle) through fill,
// key mixing and per-item keystream steps.
// ----------------------------------------------------------------------------
module rc4_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rc4_pkg::key_cfg_t    cfg_i,
  input  logic                 in_valid_i,
  input  rc4_pkg::in_item_t    in_item_i,
  output logic                 in_ready_o,
  input  logic                 res_free_i,
  output logic                 res_load_o,
  output rc4_pkg::out_item_t   res_item_o
);

  localparam int AW = rc4_pkg::SboxAddrW;

  rc4_pkg::state_e state_q, state_d;

  logic [AW-1:0]                n_q, n_d;
  logic [rc4_pkg::KeyIdxW-1:0]  kidx_q, kidx_d;
  logic [AW-1:0]                i_q, i_d;
  logic [AW-1:0]                j_q, j_d;
  logic [7:0]                   si_q, si_d;
  logic [7:0]                   sj_q, sj_d;
  logic                         fwd_q, fwd_d;
  logic                         keyed_q, keyed_d;
  logic [7:0]                   data_q, data_d;
  logic                         last_q, last_d;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [7:0]                   ram_wdata, ram_rdata;

  logic                         accept;
  logic [rc4_pkg::KeyLenW-1:0]  len_m1;
  logic [7:0]                   key_byte;
  logic [7:0]                   si_fwd;
  logic [7:0]                   ks_byte;
  logic [AW-1:0]                t_addr;

  rc4_ram #(.Width(8), .Depth(rc4_pkg::SboxDepth)) u_sbox (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == rc4_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // last key index: length zero acts as one, above the maximum saturates
  always_comb begin
    if (cfg_i.key_length == '0) begin
      len_m1 = '0;
    end else if (cfg_i.key_length > rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes)) begin
      len_m1 = rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes - 1);
    end else begin
      len_m1 = cfg_i.key_length - 1'b1;
    end
  end

  assign key_byte = cfg_i.key[{kidx_q, 3'b000} +: 8];
  // S[n+1] may have just been written by the previous swap
  assign si_fwd   = fwd_q ? si_q : ram_rdata;
  assign t_addr   = si_q + sj_q;
  assign ks_byte  = fwd_q ? si_q : ram_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.restart || !keyed_q) ? rc4_pkg::ST_FILL
                                                    : rc4_pkg::ST_P_RD_I;
        end
      end
      rc4_pkg::ST_FILL:   if (n_q == '1) state_d = rc4_pkg::ST_K_RD_J;
      rc4_pkg::ST_K_RD_J: state_d = rc4_pkg::ST_K_WR_I;
      rc4_pkg::ST_K_WR_I: state_d = rc4_pkg::ST_K_WR_J;
      rc4_pkg::ST_K_WR_J: begin
        state_d = (n_q == '1) ? rc4_pkg::ST_P_RD_I : rc4_pkg::ST_K_RD_J;
      end
      rc4_pkg::ST_P_RD_I: state_d = rc4_pkg::ST_P_RD_J;
      rc4_pkg::ST_P_RD_J: state_d = rc4_pkg::ST_P_WR_I;
      rc4_pkg::ST_P_WR_I: state_d = rc4_pkg::ST_P_WR_J;
      rc4_pkg::ST_P_WR_J: state_d = rc4_pkg::ST_P_OUT;
      rc4_pkg::ST_P_OUT:  if (res_free_i) state_d = rc4_pkg::ST_IDLE;
      default:            state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    n_d        = n_q;
    kidx_d     = kidx_q;
    i_d        = i_q;
    j_d        = j_q;
    si_d       = si_q;
    sj_d       = sj_q;
    fwd_d      = fwd_q;
    keyed_d    = keyed_q;
    data_d     = data_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_waddr  = n_q;
    ram_wdata  = n_q;
    ram_raddr  = '0;
    res_load_o = 1'b0;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          data_d    = in_item_i.data_byte;
          last_d    = in_item_i.last_in;
          n_d       = '0;
        end
      end
      rc4_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = n_q;
        ram_raddr = '0;
        n_d       = n_q + 1'b1;
        if (n_q == '1) begin
          kidx_d = '0;
          j_d    = '0;
          fwd_d  = 1'b0;
        end
      end
      rc4_pkg::ST_K_RD_J: begin
        si_d      = si_fwd;
        j_d       = j_q + si_fwd + key_byte;
        ram_raddr = j_q + si_fwd + key_byte;
      end
      rc4_pkg::ST_K_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = ram_rdata;
      end
      rc4_pkg::ST_K_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ram_raddr = n_q + 1'b1;
        fwd_d     = (j_q == AW'(n_q + 1'b1));
        n_d       = n_q + 1'b1;
        kidx_d    = ({1'b0, kidx_q} == len_m1) ? '0 : kidx_q + 1'b1;
        if (n_q == '1) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      rc4_pkg::ST_P_RD_I: begin
        i_d       = i_q + 1'b1;
        ram_raddr = i_q + 1'b1;
      end
      rc4_pkg::ST_P_RD_J: begin
        si_d      = ram_rdata;
        j_d       = j_q + ram_rdata;
        ram_raddr = j_q + ram_rdata;
      end
      rc4_pkg::ST_P_WR_I: begin
        sj_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      rc4_pkg::ST_P_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ram_raddr = t_addr;
        // the read sees the old S[j]; its new value is si
        fwd_d     = (t_addr == j_q);
      end
      rc4_pkg::ST_P_OUT: begin
        ram_raddr  = t_addr;
        res_load_o = res_free_i;
      end
      default: ;
    endcase
  end

  assign res_item_o.out_byte = data_q ^ ks_byte;
  assign res_item_o.last_out = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::ST_IDLE;
      keyed_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      kidx_q  <= '0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      keyed_q <= keyed_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      kidx_q  <= kidx_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q      <= si_d;
    sj_q      <= sj_d;
    data_q    <= data_d;
    last_q    <= last_d;
  end

endmodule
